### sv/sao_pkg.sv
`default_nettype none

package sao_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int GROUP_W   = 10;
    localparam int LENGTH_W  = 13;
    localparam int INDEX_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Signed per-pixel sum and the divider operands
    localparam int SUM_W     = 28;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int DIVD_W    = SUM_W + 1;
    localparam int DIVS_W    = GROUP_W + 1;
    localparam int STEP_W    = $clog2(DIVD_W);

    localparam logic [GROUP_W-1:0]  GROUP_MAX = GROUP_W'(1000);
    localparam logic [SAMPLE_W-1:0] VALUE_MAX = '1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GROUP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic warm_item;
        logic last_spec;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### sv/sao_ctrl.sv
`default_nettype none

module sao_ctrl
    import sao_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                // only the last spectrum of a group produces a word
                if (i_stat.warm_item && i_stat.last_spec) begin
                    n_state = ST_DIVIDE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/sao_dp.sv
`default_nettype none

module sao_dp
    import sao_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    input  wire  [SAMPLE_W-1:0]   i_sample,
    input  wire                   i_out_ready,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic [SAMPLE_W-1:0]   o_averaged_value,
    output logic [INDEX_W-1:0]    o_pixel_index,
    output logic                  o_last_pixel
);

    localparam int PW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LEN_W = $clog2(MAX_PIXELS + 1) + 1 > LENGTH_W + 1 ?
                           $clog2(MAX_PIXELS + 1) + 1 : LENGTH_W + 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PIXELS);

    // Configuration registers
    logic [GROUP_W-1:0]  r_cfg_group;
    logic [SAMPLE_W-1:0] r_cfg_offset;
    logic [LENGTH_W-1:0] r_cfg_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_group  <= GROUP_W'(1);
            r_cfg_offset <= '0;
            r_cfg_length <= LENGTH_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GROUP:  r_cfg_group  <= i_cfg_data[GROUP_W-1:0];
                REG_OFFSET: r_cfg_offset <= i_cfg_data[SAMPLE_W-1:0];
                REG_LENGTH: r_cfg_length <= i_cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    logic [GROUP_W-1:0] w_n;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_len_raw;

    assign w_len_raw = LEN_W'(r_cfg_length);

    always_comb begin
        if (r_cfg_group == '0) begin
            w_n = GROUP_W'(1);
        end else if (r_cfg_group > GROUP_MAX) begin
            w_n = GROUP_MAX;
        end else begin
            w_n = r_cfg_group;
        end
        if (w_len_raw == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_raw > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = w_len_raw;
        end
    end

    // Position counters and warmup flag
    logic [PW-1:0]      r_pos;
    logic [GROUP_W-1:0] r_group;
    logic               r_warmup;
    logic               w_last_pix;
    logic               w_last_spec;

    assign w_last_pix  = (LEN_W'(r_pos) + LEN_W'(1)) >= w_len;
    assign w_last_spec = ((GROUP_W + 1)'(r_group) + (GROUP_W + 1)'(1)) >= (GROUP_W + 1)'(w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_group  <= '0;
            r_warmup <= 1'b0;
        end else if (i_cmd.accept) begin
            if (w_last_pix) begin
                r_pos <= '0;
                if (!r_warmup) begin
                    r_warmup <= 1'b1;
                end else begin
                    r_group <= w_last_spec ? '0 : r_group + GROUP_W'(1);
                end
            end else begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    // Item capture
    logic [SAMPLE_W-1:0] r_sample;
    logic [PW-1:0]       r_item_pos;
    logic                r_item_last_pix;
    logic                r_item_last_spec;
    logic                r_item_first;
    logic                r_item_warm;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample         <= i_sample;
            r_item_pos       <= r_pos;
            r_item_last_pix  <= w_last_pix;
            r_item_last_spec <= w_last_spec;
            r_item_first     <= (r_group == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_warm <= 1'b0;
        end else if (i_cmd.accept) begin
            r_item_warm <= r_warmup;
        end
    end

    // Per-pixel sum memory
    logic signed [SUM_W-1:0] r_sums [MAX_PIXELS];
    logic signed [SUM_W-1:0] r_rd;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [SUM_W-1:0]  w_sum;

    assign w_diff = $signed({1'b0, r_sample}) - $signed({1'b0, r_cfg_offset});
    assign w_sum  = r_item_first ? SUM_W'(w_diff) : r_rd + SUM_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_sums[r_pos];
        end
        if (i_cmd.update && r_item_warm) begin
            r_sums[r_item_pos] <= w_sum;
        end
    end

    // Restoring divider, one quotient bit per cycle: (2*sum + n) / (2*n)
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_divs;
    logic [DIVS_W-1:0] r_rem;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] w_divd;
    logic [DIVS_W:0]   w_rem_sh;
    logic              w_ge;
    logic              w_sum_pos;

    assign w_sum_pos = !w_sum[SUM_W-1] && (w_sum != '0);
    assign w_divd    = w_sum_pos ?
                       ({1'b0, w_sum[SUM_W-2:0], 1'b0} + DIVD_W'(w_n)) : '0;
    assign w_rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_divs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_quo  <= w_divd;
            r_divs <= {w_n, 1'b0};
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem  <= w_ge ? DIVS_W'(w_rem_sh - {1'b0, r_divs}) : w_rem_sh[DIVS_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            // clamp quotients above the 16-bit range
            o_averaged_value <= (r_quo[DIVD_W-1:SAMPLE_W] != '0) ?
                                VALUE_MAX : r_quo[SAMPLE_W-1:0];
            o_pixel_index    <= INDEX_W'(r_item_pos);
            o_last_pixel     <= r_item_last_pix;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.warm_item  = r_item_warm;
    assign o_stat.last_spec  = r_item_last_spec;
    assign o_stat.div_last   = (r_step == STEP_W'(DIVD_W - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

### sv/spectrum_average_offset.sv
`default_nettype none

// Averages spectrometer spectra in groups after dark-offset subtraction.
// Samples enter in pixel order; the first whole spectrum after reset is
// dropped. Each pixel keeps a signed sum in a MAX_PIXELS-deep memory, and
// on the last spectrum of a group the block emits sum / group size, rounded
// half away from zero and clamped to 0..65535, with pixel index and a
// last-pixel flag. An item that only accumulates goes through accept, then
// memory read-modify-write; one that yields a word also passes a
// one-bit-per-cycle restoring divider and the output register load. A
// waiting output word does not block accumulation of later samples until
// the next word is due. Configuration writes take effect at once; the user
// must make them only while the block is idle; the block does not check.

module spectrum_average_offset
    import sao_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]      i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [SAMPLE_W-1:0]   o_averaged_value,
    output logic [INDEX_W-1:0]    o_pixel_index,
    output logic                  o_last_pixel
);

    t_cmd  w_cmd;
    t_stat w_stat;

    sao_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sao_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_out_ready      (i_out_ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .o_averaged_value (o_averaged_value),
        .o_pixel_index    (o_pixel_index),
        .o_last_pixel     (o_last_pixel)
    );

endmodule

`default_nettype wire

### sv/sao_checker.sv
`default_nettype none

module sao_checker
    import sao_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire [SAMPLE_W-1:0]  o_averaged_value,
    input wire [INDEX_W-1:0]   o_pixel_index,
    input wire                 o_last_pixel
);

    // no word right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_averaged_value)
            && $stable(o_pixel_index) && $stable(o_last_pixel))
        else $error("stalled output word changed");

    // one sample at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // a new word appears only while the input side is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output word loaded while idle");

endmodule

bind spectrum_average_offset sao_checker u_sao_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_averaged_value (o_averaged_value),
    .o_pixel_index    (o_pixel_index),
    .o_last_pixel     (o_last_pixel)
);

`default_nettype wire

### tb/tb.sv
module tb;
    import sao_pkg::*;

    localparam int          PIXELS      = 4096;
    localparam int          SETTLE_CYC  = 40;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          TOTAL_ITEMS = 850;
    localparam int          LONG_PIXELS = 150;
    localparam int          HELD_SPECTRA = 200;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]  index;
        logic                last;
    } t_mean_word;

    // Tracks the per-pixel sums and the words they should produce.
    class average_board;
        logic [GROUP_W-1:0]  group_reg;
        logic [SAMPLE_W-1:0] offset_reg;
        logic [LENGTH_W-1:0] length_reg;
        int                  sums [PIXELS];
        int unsigned         pixel;
        int unsigned         spectrum;
        bit                  warm;
        int unsigned         high_water;
        t_mean_word          due [$];
        int                  errors;

        function new();
            group_reg  = GROUP_W'(1);
            offset_reg = '0;
            length_reg = LENGTH_W'(1024);
            pixel      = 0;
            spectrum   = 0;
            warm       = 1'b0;
            high_water = 0;
            errors     = 0;
        endfunction

        function int unsigned clamp_group(logic [GROUP_W-1:0] v);
            if (v == 0) return 1;
            if (v > 1000) return 1000;
            return 32'(v);
        endfunction

        function int unsigned clamp_length(logic [LENGTH_W-1:0] v);
            if (v == 0) return 1;
            if (v > PIXELS) return PIXELS;
            return 32'(v);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_GROUP:  group_reg  = data[GROUP_W-1:0];
                REG_OFFSET: offset_reg = data[SAMPLE_W-1:0];
                REG_LENGTH: length_reg = data[LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        // A longer spectrum mid-group must not reach sums never written.
        function bit length_safe(logic [LENGTH_W-1:0] v);
            return !warm || (pixel == 0 && spectrum == 0) || clamp_length(v) <= high_water;
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            int unsigned len;
            int unsigned n;
            int unsigned p;
            bit          last_pix;
            bit          last_spec;
            int          total;
            longint      q;
            t_mean_word  w;
            len = clamp_length(length_reg);
            n   = clamp_group(group_reg);
            p   = (pixel >= PIXELS) ? PIXELS - 1 : pixel;
            last_pix = (p + 1 >= len);
            if (!warm) begin
                if (last_pix) begin
                    warm  = 1'b1;
                    pixel = 0;
                end else begin
                    pixel = p + 1;
                end
                return;
            end
            last_spec = (spectrum + 1 >= n);
            total = int'(s) - int'(offset_reg);
            if (spectrum != 0) total += sums[p];
            sums[p] = total;
            if (p + 1 > high_water) high_water = p + 1;
            if (last_spec) begin
                if (total <= 0) begin
                    q = 0;
                end else begin
                    q = (2 * longint'(total) + longint'(n)) / (2 * longint'(n));
                    if (q > 65535) q = 65535;
                end
                w.value = q[SAMPLE_W-1:0];
                w.index = p[INDEX_W-1:0];
                w.last  = last_pix;
                due.push_back(w);
            end
            if (last_pix) begin
                pixel    = 0;
                spectrum = last_spec ? 0 : spectrum + 1;
            end else begin
                pixel = p + 1;
            end
        endfunction

        function void check_word(logic [SAMPLE_W-1:0] v, logic [INDEX_W-1:0] ix, logic l);
            t_mean_word w;
            if (due.size() == 0) begin
                $error("unexpected word: averaged_value %0d pixel_index %0d", v, ix);
                errors++;
                return;
            end
            w = due.pop_front();
            if (v !== w.value) begin
                $error("averaged_value: expected %0d, actual %0d", w.value, v);
                errors++;
            end
            if (ix !== w.index) begin
                $error("pixel_index: expected %0d, actual %0d", w.index, ix);
                errors++;
            end
            if (l !== w.last) begin
                $error("last_pixel: expected %0d, actual %0d", w.last, l);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic [SAMPLE_W-1:0]  i_sample     = '0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [SAMPLE_W-1:0]  o_averaged_value;
    logic [INDEX_W-1:0]   o_pixel_index;
    logic                 o_last_pixel;

    average_board book;
    int           send_idle   = 0;
    int           recv_idle   = 0;
    int           sent        = 0;
    int           cycles      = 0;

    spectrum_average_offset uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_averaged_value (o_averaged_value),
        .o_pixel_index    (o_pixel_index),
        .o_last_pixel     (o_last_pixel)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_word(o_averaged_value, o_pixel_index, o_last_pixel);

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle = send_pct;
        recv_idle = recv_pct;
    endtask

    // Lower the enable after each write and wait with it low so it drops cleanly.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        // Both idle, the receiver more at first, then the sender more, then neither.
        if (sent < TOTAL_ITEMS / 3)
            set_idling(32, 48);
        else if (sent < 2 * TOTAL_ITEMS / 3)
            set_idling(48, 32);
        else
            set_idling(0, 0);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        book.take_sample(s);
        sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, drain every expected word, then give the block time to finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (book.due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned style);
        int v;
        case (style)
            0: v = $urandom_range(65535);
            1: v = int'(book.offset_reg) + int'($urandom_range(300)) - 150;
            2: v = $urandom_range(1) ? 65535 : 0;
            default: v = $urandom_range(255);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic random_phase();
        int unsigned         pick;
        int unsigned         style;
        int unsigned         count;
        int unsigned         per_group;
        logic [LENGTH_W-1:0] new_len;
        logic [GROUP_W-1:0]  new_group;
        logic [SAMPLE_W-1:0] new_offset;
        settle();
        if ($urandom_range(2) == 0) begin
            pick = $urandom_range(99);
            if (pick < 40)      new_offset = SAMPLE_W'($urandom_range(200));
            else if (pick < 60) new_offset = SAMPLE_W'($urandom_range(65535));
            else if (pick < 70) new_offset = '1;
            else                new_offset = SAMPLE_W'($urandom_range(1000));
            write_reg(REG_OFFSET, new_offset);
        end
        if ($urandom_range(2) == 0) begin
            pick = $urandom_range(99);
            if (pick < 80)      new_group = GROUP_W'($urandom_range(4, 1));
            else if (pick < 90) new_group = '0;
            else                new_group = GROUP_W'($urandom_range(8, 5));
            write_reg(REG_GROUP, {6'($urandom_range(63)), new_group});
        end
        if ($urandom_range(2) == 0) begin
            pick = $urandom_range(99);
            if (pick < 70)      new_len = LENGTH_W'($urandom_range(8, 1));
            else if (pick < 85) new_len = LENGTH_W'($urandom_range(16, 9));
            else if (pick < 95) new_len = '0;
            else                new_len = LENGTH_W'($urandom_range(40, 17));
            if (book.length_safe(new_len))
                write_reg(REG_LENGTH, {3'($urandom_range(7)), new_len});
        end
        style     = $urandom_range(3);
        per_group = book.clamp_group(book.group_reg) * book.clamp_length(book.length_reg);
        // Mostly whole groups; the rest stop anywhere in a spectrum or group.
        if ($urandom_range(99) < 75 && per_group <= 64)
            count = per_group * $urandom_range(2, 1);
        else
            count = $urandom_range(2 * book.clamp_length(book.length_reg), 1);
        repeat (count) push_sample(pick_sample(style));
    endtask

    initial begin
        book = new();
        set_idling(32, 48);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Warmup spectrum is dropped, then one spectrum averaged over one.
        write_reg(REG_GROUP, 16'd1);
        write_reg(REG_OFFSET, 16'd0);
        write_reg(REG_LENGTH, 16'd3);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);

        // Round half away from zero, and a negative mean clamped to zero.
        settle();
        write_reg(REG_OFFSET, 16'd100);
        write_reg(REG_GROUP, 16'd2);
        push_sample(16'd101);
        push_sample(16'd50);
        push_sample(16'd100);
        push_sample(16'd102);
        push_sample(16'd50);
        push_sample(16'd101);

        // Shrink the group mid-group so the mean overflows and clamps high.
        settle();
        write_reg(REG_OFFSET, 16'd0);
        write_reg(REG_GROUP, 16'd3);
        write_reg(REG_LENGTH, 16'd2);
        push_sample(16'hFFFF);
        push_sample(16'hFFFF);
        settle();
        write_reg(REG_GROUP, 16'd0);
        push_sample(16'hFFFF);
        push_sample(16'hFFFF);

        // Zero length acts as one pixel; spare index is ignored.
        settle();
        write_reg(REG_OFFSET, 16'hFFFF);
        write_reg(REG_LENGTH, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);
        push_sample(16'hFFFF);
        push_sample(16'h0000);

        // Length beyond range clamps to the full array; a shorter length
        // then ends the spectrum on the next pixel.
        settle();
        write_reg(REG_GROUP, 16'd1);
        write_reg(REG_LENGTH, 16'hFFFF);
        write_reg(REG_OFFSET, 16'($urandom_range(2000)));
        repeat (LONG_PIXELS) push_sample(pick_sample(0));
        settle();
        write_reg(REG_LENGTH, 16'd1);
        push_sample(pick_sample(0));

        // Group beyond range holds back every word; a smaller group then
        // closes it on a large full-scale sum that clamps high.
        settle();
        write_reg(REG_GROUP, 16'hFFFF);
        write_reg(REG_OFFSET, 16'd0);
        repeat (HELD_SPECTRA) push_sample(16'hFFFF);
        settle();
        write_reg(REG_GROUP, 16'd5);
        push_sample(16'hFFFF);

        while (sent < TOTAL_ITEMS)
            random_phase();
        settle();

        if (book.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/sao_pkg.sv
sv/sao_ctrl.sv
sv/sao_dp.sv
sv/spectrum_average_offset.sv
sv/sao_checker.sv
tb/tb.sv
